FILE: sv/rmj_pkg.sv
// Package for the radar measurement Jacobian pipeline.
// Holds the fixed-point format, the step counts of the iterative units and helper functions.
// No dependencies.
`default_nettype none

package rmj_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned WIDE_W      = 2 * DATA_W;
  localparam int unsigned SQRT_STEPS  = DATA_W;
  localparam int unsigned RANGE_STEPS = FRAC_BITS + 1;
  localparam int unsigned BEAR_STEPS  = 2 * FRAC_BITS + 1;
  localparam int unsigned RATE_STEPS  = DATA_W - 1 + FRAC_BITS;
  localparam int unsigned Q_W         = RATE_STEPS + 1;
  localparam int unsigned RANGE_LAT   = SQRT_STEPS + RANGE_STEPS;
  localparam logic [CFG_W-1:0] MIN_RESET = CFG_W'(7);

  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (DATA_W'(0) - v) : v;
  endfunction

  function automatic logic [DATA_W-1:0] to_out(input logic [WIDE_W-1:0] mag, input logic neg);
    logic [WIDE_W-1:0] lim;
    lim = neg ? (WIDE_W'(1) << (DATA_W - 1)) : ((WIDE_W'(1) << (DATA_W - 1)) - WIDE_W'(1));
    if (mag > lim) begin
      mag = lim;
    end
    return neg ? (DATA_W'(0) - mag[DATA_W-1:0]) : mag[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/radar_measurement_jacobian.sv
// Top level of the radar measurement Jacobian pipeline.
// Depends on rmj_pkg, rmj_sqrt_pipe, rmj_div_pipe and rmj_delay_line.
//
// One item enters in every clock cycle and its result appears on the result ports, marked by
// done_o, after the input registers, the 32 square root stages, the 17 range divider stages
// and the output registers. The square root feeding the range divider is the longest path; busy
// is never raised, so results never need to be held.
`default_nettype none

module radar_measurement_jacobian (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                min_range_squared_we_i,
  input  wire logic        [rmj_pkg::CFG_W-1:0]    min_range_squared_i,
  input  wire logic signed [rmj_pkg::DATA_W-1:0]   pos_x_i,
  input  wire logic signed [rmj_pkg::DATA_W-1:0]   pos_y_i,
  input  wire logic signed [rmj_pkg::DATA_W-1:0]   vel_x_i,
  input  wire logic signed [rmj_pkg::DATA_W-1:0]   vel_y_i,
  output logic                                     done_o,
  output logic signed      [rmj_pkg::DATA_W-1:0]   range_wrt_x_o,
  output logic signed      [rmj_pkg::DATA_W-1:0]   range_wrt_y_o,
  output logic signed      [rmj_pkg::DATA_W-1:0]   bearing_wrt_x_o,
  output logic signed      [rmj_pkg::DATA_W-1:0]   bearing_wrt_y_o,
  output logic signed      [rmj_pkg::DATA_W-1:0]   rate_wrt_x_o,
  output logic signed      [rmj_pkg::DATA_W-1:0]   rate_wrt_y_o,
  output logic                                     well_defined_o
);
  import rmj_pkg::*;

  localparam int unsigned QLO        = Q_W / 2;
  localparam int unsigned QHI        = Q_W - QLO;
  localparam int unsigned PW         = RANGE_STEPS + Q_W;
  localparam int unsigned SIDE_W     = 6;
  localparam int unsigned PIPE_DEPTH = 5 + RANGE_LAT;
  localparam logic signed [DATA_W-1:0] UNIT = DATA_W'(1) << FRAC_BITS;

  logic [CFG_W-1:0] min_q;
  logic             accept;

  logic              v0_q, nx0_q, ny0_q, nvx0_q, nvy0_q;
  logic [DATA_W-1:0] ax0_q, ay0_q, avx0_q, avy0_q;
  logic              v1_q, nx1_q, ny1_q, s1_q, t2_q;
  logic [DATA_W-1:0] ax1_q, ay1_q;
  logic [WIDE_W-1:0] pxx_q, pyy_q, p1_q, p2_q;
  logic              v2_q, nx2_q, ny2_q, nc2_q, ok2_q, qsat2_q;
  logic [DATA_W-1:0] ax2_q, ay2_q;
  logic [WIDE_W-1:0] d2_q, cm2_q;
  logic [WIDE_W-1:0] d_d, cm_d;
  logic              nc_d;

  logic [DATA_W-1:0]      root;
  logic [2*DATA_W-1:0]    axy_r;
  logic [DATA_W-1:0]      ax_r, ay_r;
  logic [RANGE_STEPS-1:0] rx, ry;
  logic [BEAR_STEPS-1:0]  bx_raw, by_raw, bx, by;
  logic [RATE_STEPS-1:0]  q_raw, q_al;
  logic [SIDE_W-1:0]      side;
  logic [Q_W-1:0]         q;

  logic                     v3_q, ok3_q, nx3_q, ny3_q, nc3_q;
  logic [RANGE_STEPS-1:0]   rx3_q, ry3_q;
  logic [BEAR_STEPS-1:0]    bx3_q, by3_q;
  logic [RANGE_STEPS+QLO-1:0] ry_lo_q, rx_lo_q;
  logic [RANGE_STEPS+QHI-1:0] ry_hi_q, rx_hi_q;
  logic [PW-1:0]            ry_q_prod, rx_q_prod;

  logic              done_q, well_q;
  logic [DATA_W-1:0] rgx_q, rgy_q, bgx_q, bgy_q, rtx_q, rty_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_RESET;
    end else if (min_range_squared_we_i) begin
      min_q <= min_range_squared_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v0_q <= accept;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= side[5];
      done_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax0_q  <= mag32(pos_x_i);
    ay0_q  <= mag32(pos_y_i);
    avx0_q <= mag32(vel_x_i);
    avy0_q <= mag32(vel_y_i);
    nx0_q  <= pos_x_i[DATA_W-1];
    ny0_q  <= pos_y_i[DATA_W-1];
    nvx0_q <= vel_x_i[DATA_W-1];
    nvy0_q <= vel_y_i[DATA_W-1];
  end

  always_ff @(posedge clk_i) begin
    pxx_q <= WIDE_W'(ax0_q) * WIDE_W'(ax0_q);
    pyy_q <= WIDE_W'(ay0_q) * WIDE_W'(ay0_q);
    p1_q  <= WIDE_W'(avx0_q) * WIDE_W'(ay0_q);
    p2_q  <= WIDE_W'(avy0_q) * WIDE_W'(ax0_q);
    s1_q  <= nvx0_q ^ ny0_q;
    t2_q  <= ~(nvy0_q ^ nx0_q);
    ax1_q <= ax0_q;
    ay1_q <= ay0_q;
    nx1_q <= nx0_q;
    ny1_q <= ny0_q;
  end

  always_comb begin
    d_d = pxx_q + pyy_q;
    if (s1_q == t2_q) begin
      cm_d = p1_q + p2_q;
      nc_d = s1_q;
    end else if (p1_q >= p2_q) begin
      cm_d = p1_q - p2_q;
      nc_d = s1_q;
    end else begin
      cm_d = p2_q - p1_q;
      nc_d = t2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d2_q    <= d_d;
    cm2_q   <= cm_d;
    nc2_q   <= nc_d;
    ok2_q   <= d_d > (WIDE_W'(min_q) << FRAC_BITS);
    qsat2_q <= (cm_d >> (DATA_W - 1)) >= d_d;
    ax2_q   <= ax1_q;
    ay2_q   <= ay1_q;
    nx2_q   <= nx1_q;
    ny2_q   <= ny1_q;
  end

  rmj_sqrt_pipe u_sqrt (
    .clk_i      (clk_i),
    .radicand_i (d2_q),
    .root_o     (root)
  );

  rmj_delay_line #(.W(2 * DATA_W), .DEPTH(SQRT_STEPS)) u_axy_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .data_i ({ax2_q, ay2_q}),
    .data_o (axy_r)
  );
  assign ax_r = axy_r[2*DATA_W-1:DATA_W];
  assign ay_r = axy_r[DATA_W-1:0];

  rmj_div_pipe #(.DW(DATA_W), .STEPS(RANGE_STEPS)) u_div_rx (
    .clk_i  (clk_i),
    .rem_i  (ax_r >> 1),
    .den_i  (root),
    .bits_i ({ax_r[0], FRAC_BITS'(0)}),
    .quot_o (rx)
  );

  rmj_div_pipe #(.DW(DATA_W), .STEPS(RANGE_STEPS)) u_div_ry (
    .clk_i  (clk_i),
    .rem_i  (ay_r >> 1),
    .den_i  (root),
    .bits_i ({ay_r[0], FRAC_BITS'(0)}),
    .quot_o (ry)
  );

  rmj_div_pipe #(.DW(WIDE_W), .STEPS(BEAR_STEPS)) u_div_bx (
    .clk_i  (clk_i),
    .rem_i  (WIDE_W'(ay2_q >> 1)),
    .den_i  (d2_q),
    .bits_i ({ay2_q[0], (2 * FRAC_BITS)'(0)}),
    .quot_o (bx_raw)
  );

  rmj_div_pipe #(.DW(WIDE_W), .STEPS(BEAR_STEPS)) u_div_by (
    .clk_i  (clk_i),
    .rem_i  (WIDE_W'(ax2_q >> 1)),
    .den_i  (d2_q),
    .bits_i ({ax2_q[0], (2 * FRAC_BITS)'(0)}),
    .quot_o (by_raw)
  );

  rmj_div_pipe #(.DW(WIDE_W), .STEPS(RATE_STEPS)) u_div_rate (
    .clk_i  (clk_i),
    .rem_i  (cm2_q >> (DATA_W - 1)),
    .den_i  (d2_q),
    .bits_i ({cm2_q[DATA_W-2:0], FRAC_BITS'(0)}),
    .quot_o (q_raw)
  );

  rmj_delay_line #(.W(2 * BEAR_STEPS), .DEPTH(RANGE_LAT - BEAR_STEPS)) u_bear_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .data_i ({bx_raw, by_raw}),
    .data_o ({bx, by})
  );

  rmj_delay_line #(.W(RATE_STEPS), .DEPTH(RANGE_LAT - RATE_STEPS)) u_rate_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .data_i (q_raw),
    .data_o (q_al)
  );

  rmj_delay_line #(.W(SIDE_W), .DEPTH(RANGE_LAT)) u_side_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .data_i ({v2_q, ok2_q, nx2_q, ny2_q, nc2_q, qsat2_q}),
    .data_o (side)
  );

  assign q = side[0] ? (Q_W'(1) << (Q_W - 1)) : {1'b0, q_al};

  always_ff @(posedge clk_i) begin
    ok3_q   <= side[4];
    nx3_q   <= side[3];
    ny3_q   <= side[2];
    nc3_q   <= side[1];
    rx3_q   <= rx;
    ry3_q   <= ry;
    bx3_q   <= bx;
    by3_q   <= by;
    ry_lo_q <= (RANGE_STEPS + QLO)'(ry) * (RANGE_STEPS + QLO)'(q[QLO-1:0]);
    ry_hi_q <= (RANGE_STEPS + QHI)'(ry) * (RANGE_STEPS + QHI)'(q[Q_W-1:QLO]);
    rx_lo_q <= (RANGE_STEPS + QLO)'(rx) * (RANGE_STEPS + QLO)'(q[QLO-1:0]);
    rx_hi_q <= (RANGE_STEPS + QHI)'(rx) * (RANGE_STEPS + QHI)'(q[Q_W-1:QLO]);
  end

  assign ry_q_prod = (PW'(ry_hi_q) << QLO) + PW'(ry_lo_q);
  assign rx_q_prod = (PW'(rx_hi_q) << QLO) + PW'(rx_lo_q);

  always_ff @(posedge clk_i) begin
    well_q <= ok3_q;
    if (ok3_q) begin
      rgx_q <= to_out(WIDE_W'(rx3_q), nx3_q);
      rgy_q <= to_out(WIDE_W'(ry3_q), ny3_q);
      bgx_q <= to_out(WIDE_W'(bx3_q), ~ny3_q);
      bgy_q <= to_out(WIDE_W'(by3_q), nx3_q);
      rtx_q <= to_out(WIDE_W'(ry_q_prod >> FRAC_BITS), ny3_q ^ nc3_q);
      rty_q <= to_out(WIDE_W'(rx_q_prod >> FRAC_BITS), nx3_q ^ ~nc3_q);
    end else begin
      rgx_q <= '0;
      rgy_q <= '0;
      bgx_q <= '0;
      bgy_q <= '0;
      rtx_q <= '0;
      rty_q <= '0;
    end
  end

  assign done_o          = done_q;
  assign well_defined_o  = well_q;
  assign range_wrt_x_o   = rgx_q;
  assign range_wrt_y_o   = rgy_q;
  assign bearing_wrt_x_o = bgx_q;
  assign bearing_wrt_y_o = bgy_q;
  assign rate_wrt_x_o    = rtx_q;
  assign rate_wrt_y_o    = rty_q;

  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##PIPE_DEPTH done_o)
    else $error("An accepted item did not produce a result at the expected cycle.");

  a_latency_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, PIPE_DEPTH))
    else $error("A result appeared without a matching accepted item.");

  a_zero_when_undefined: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !well_defined_o |-> range_wrt_x_o == 0 && range_wrt_y_o == 0 &&
      bearing_wrt_x_o == 0 && bearing_wrt_y_o == 0 && rate_wrt_x_o == 0 && rate_wrt_y_o == 0)
    else $error("Entries are nonzero although the range is too small.");

  a_range_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && well_defined_o |-> range_wrt_x_o <= UNIT && range_wrt_x_o >= -UNIT &&
      range_wrt_y_o <= UNIT && range_wrt_y_o >= -UNIT)
    else $error("A range entry exceeds one in magnitude.");

endmodule

`default_nettype wire

FILE: sv/rmj_sqrt_pipe.sv
// Pipelined bitwise integer square root, one result bit per register stage.
// Depends on rmj_pkg.
`default_nettype none

module rmj_sqrt_pipe (
  input  wire logic                         clk_i,
  input  wire logic [rmj_pkg::WIDE_W-1:0]   radicand_i,
  output logic      [rmj_pkg::DATA_W-1:0]   root_o
);
  import rmj_pkg::*;

  logic [WIDE_W-1:0] n_q   [SQRT_STEPS];
  logic [WIDE_W-1:0] res_q [SQRT_STEPS];

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_stage
    localparam logic [WIDE_W-1:0] StepBit = WIDE_W'(1) << (WIDE_W - 2 - 2 * s);
    logic [WIDE_W-1:0] n_p, res_p, trial;
    logic              fits;
    if (s == 0) begin : g_first
      assign n_p   = radicand_i;
      assign res_p = '0;
    end else begin : g_next
      assign n_p   = n_q[s-1];
      assign res_p = res_q[s-1];
    end
    assign trial = res_p + StepBit;
    assign fits  = n_p >= trial;
    always_ff @(posedge clk_i) begin
      n_q[s]   <= fits ? (n_p - trial) : n_p;
      res_q[s] <= fits ? ((res_p >> 1) + StepBit) : (res_p >> 1);
    end
  end

  assign root_o = res_q[SQRT_STEPS-1][DATA_W-1:0];

endmodule

`default_nettype wire

FILE: sv/rmj_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// The partial remainder must start below the divisor. Depends on rmj_pkg.
`default_nettype none

module rmj_div_pipe #(
  parameter int unsigned DW    = 64,
  parameter int unsigned STEPS = 17
) (
  input  wire logic             clk_i,
  input  wire logic [DW-1:0]    rem_i,
  input  wire logic [DW-1:0]    den_i,
  input  wire logic [STEPS-1:0] bits_i,
  output logic      [STEPS-1:0] quot_o
);
  import rmj_pkg::*;

  logic [DW-1:0]    rem_q  [STEPS];
  logic [DW-1:0]    den_q  [STEPS];
  logic [STEPS-1:0] bits_q [STEPS];
  logic [STEPS-1:0] quot_q [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_stage
    logic [DW-1:0]    rem_p, den_p;
    logic [STEPS-1:0] bits_p, quot_p;
    logic [DW:0]      trial;
    logic             fits;
    if (s == 0) begin : g_first
      assign rem_p  = rem_i;
      assign den_p  = den_i;
      assign bits_p = bits_i;
      assign quot_p = '0;
    end else begin : g_next
      assign rem_p  = rem_q[s-1];
      assign den_p  = den_q[s-1];
      assign bits_p = bits_q[s-1];
      assign quot_p = quot_q[s-1];
    end
    assign trial = {rem_p, bits_p[STEPS-1-s]};
    assign fits  = trial >= {1'b0, den_p};
    always_ff @(posedge clk_i) begin
      rem_q[s]  <= fits ? DW'(trial - {1'b0, den_p}) : trial[DW-1:0];
      den_q[s]  <= den_p;
      bits_q[s] <= bits_p;
      quot_q[s] <= {quot_p[STEPS-2:0], fits};
    end
  end

  assign quot_o = quot_q[STEPS-1];

endmodule

`default_nettype wire

FILE: sv/rmj_delay_line.sv
// Fixed-length register delay line that keeps side data in step with the arithmetic units.
// Depends on rmj_pkg.
`default_nettype none

module rmj_delay_line #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic [W-1:0] data_i,
  output logic      [W-1:0] data_o
);
  import rmj_pkg::*;

  logic [W-1:0] tap_q [DEPTH];

  for (genvar s = 0; s < DEPTH; s++) begin : g_tap
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tap_q[s] <= '0;
      end else begin
        tap_q[s] <= (s == 0) ? data_i : tap_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  assign data_o = tap_q[DEPTH-1];

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for radar_measurement_jacobian: drives state vectors,
// predicts each Jacobian in fixed point and compares every field at done_o.
// Depends on rmj_pkg and the radar_measurement_jacobian RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rmj_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 70;

  typedef struct packed {
    logic [DATA_W-1:0] pos_x;
    logic [DATA_W-1:0] pos_y;
    logic [DATA_W-1:0] vel_x;
    logic [DATA_W-1:0] vel_y;
  } track_state_t;

  typedef struct packed {
    logic [DATA_W-1:0] range_wrt_x;
    logic [DATA_W-1:0] range_wrt_y;
    logic [DATA_W-1:0] bearing_wrt_x;
    logic [DATA_W-1:0] bearing_wrt_y;
    logic [DATA_W-1:0] rate_wrt_x;
    logic [DATA_W-1:0] rate_wrt_y;
    logic              well_defined;
  } jacobian_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_data;
  logic signed [DATA_W-1:0] pos_x, pos_y, vel_x, vel_y;
  logic done;
  logic signed [DATA_W-1:0] rng_x, rng_y, brg_x, brg_y, rte_x, rte_y;
  logic well_def;

  track_state_t state_pending_q[$];
  jacobian_t    jacobian_expect_q[$];
  logic [CFG_W-1:0] min_range_model;
  int unsigned sender_idle_pct;
  int unsigned cycle_count;
  bit failed;

  radar_measurement_jacobian u_top (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .start                 (start),
    .busy                  (busy),
    .min_range_squared_we_i(cfg_we),
    .min_range_squared_i   (cfg_data),
    .pos_x_i               (pos_x),
    .pos_y_i               (pos_y),
    .vel_x_i               (vel_x),
    .vel_y_i               (vel_y),
    .done_o                (done),
    .range_wrt_x_o         (rng_x),
    .range_wrt_y_o         (rng_y),
    .bearing_wrt_x_o       (brg_x),
    .bearing_wrt_y_o       (brg_y),
    .rate_wrt_x_o          (rte_x),
    .rate_wrt_y_o          (rte_y),
    .well_defined_o        (well_def)
  );

  function automatic logic [63:0] abs_q16(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (64'h1_0000_0000 - {32'b0, v}) : {32'b0, v};
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= res + bit_w) begin
        n = n - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] scaled_quotient(input logic [63:0] num,
                                                  input logic [63:0] den, input int sh);
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] cap;
    bit sat;
    cap = 64'd1 << 62;
    q = num / den;
    rem = num % den;
    sat = q > cap;
    for (int i = 0; i < sh; i++) begin
      if (q > cap) sat = 1;
      if (sat) q = cap;
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    if (sat || q > cap) q = cap;
    return q;
  endfunction

  function automatic logic [63:0] clamp_product(input logic [63:0] a, input logic [63:0] b);
    if (a != 0 && b > ({64{1'b1}} / a)) return {64{1'b1}};
    return a * b;
  endfunction

  function automatic logic [DATA_W-1:0] saturate_q16(input logic [63:0] m, input bit neg);
    if (neg) begin
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      return 32'(64'd0 - m);
    end
    if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
    return m[31:0];
  endfunction

  function automatic jacobian_t predict_jacobian(input track_state_t s,
                                                 input logic [CFG_W-1:0] thr);
    jacobian_t j;
    logic [63:0] ax, ay, avx, avy, d, r, rx, ry, p1, p2, cm, q;
    bit nx, ny, nvx, nvy, s1, t2, nc;
    j = '0;
    nx = s.pos_x[31]; ny = s.pos_y[31]; nvx = s.vel_x[31]; nvy = s.vel_y[31];
    ax = abs_q16(s.pos_x); ay = abs_q16(s.pos_y);
    avx = abs_q16(s.vel_x); avy = abs_q16(s.vel_y);
    d = ax * ax + ay * ay;
    if (d <= ({48'b0, thr} << FRAC_BITS)) return j;
    r = floor_sqrt(d);
    rx = (ax << FRAC_BITS) / r;
    ry = (ay << FRAC_BITS) / r;
    j.range_wrt_x = saturate_q16(rx, nx);
    j.range_wrt_y = saturate_q16(ry, ny);
    j.bearing_wrt_x = saturate_q16(scaled_quotient(ay, d, 2 * FRAC_BITS), !ny);
    j.bearing_wrt_y = saturate_q16(scaled_quotient(ax, d, 2 * FRAC_BITS), nx);
    p1 = avx * ay;
    s1 = nvx != ny;
    p2 = avy * ax;
    t2 = !(nvy != nx);
    if (s1 == t2) begin
      cm = p1 + p2; nc = s1;
    end else if (p1 >= p2) begin
      cm = p1 - p2; nc = s1;
    end else begin
      cm = p2 - p1; nc = t2;
    end
    q = scaled_quotient(cm, d, FRAC_BITS);
    j.rate_wrt_x = saturate_q16(clamp_product(ry, q) >> FRAC_BITS, ny != nc);
    j.rate_wrt_y = saturate_q16(clamp_product(rx, q) >> FRAC_BITS, nx != !nc);
    j.well_defined = 1'b1;
    return j;
  endfunction

  function automatic logic [DATA_W-1:0] random_q16();
    logic [DATA_W-1:0] v;
    int unsigned w;
    w = $urandom_range(32, 0);
    v = $urandom;
    if (w < 32) v = v & ((32'd1 << w) - 1);
    if ($urandom_range(1, 0) == 1) v = 32'd0 - v;
    return v;
  endfunction

  task automatic queue_state(input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] vx, input logic [31:0] vy);
    state_pending_q.push_back('{pos_x: px, pos_y: py, vel_x: vx, vel_y: vy});
  endtask

  task automatic wait_drained();
    while (state_pending_q.size() != 0 || jacobian_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_min_range(input logic [CFG_W-1:0] v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_data <= v;
    min_range_model = v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Driver: the item on the ports stays until taken; the next one is chosen after that.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        jacobian_expect_q.push_back(predict_jacobian(state_pending_q[0], min_range_model));
        void'(state_pending_q.pop_front());
      end
      if (!(start && busy)) begin
        if (state_pending_q.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
          start <= 1'b1;
          pos_x <= state_pending_q[0].pos_x;
          pos_y <= state_pending_q[0].pos_y;
          vel_x <= state_pending_q[0].vel_x;
          vel_y <= state_pending_q[0].vel_y;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    jacobian_t e;
    if (rst_ni && done) begin
      if (jacobian_expect_q.size() == 0) begin
        $error("unexpected result");
        failed = 1;
      end else begin
        e = jacobian_expect_q.pop_front();
        if (rng_x !== e.range_wrt_x) begin
          $error("range_wrt_x expected %h actual %h", e.range_wrt_x, rng_x); failed = 1;
        end
        if (rng_y !== e.range_wrt_y) begin
          $error("range_wrt_y expected %h actual %h", e.range_wrt_y, rng_y); failed = 1;
        end
        if (brg_x !== e.bearing_wrt_x) begin
          $error("bearing_wrt_x expected %h actual %h", e.bearing_wrt_x, brg_x); failed = 1;
        end
        if (brg_y !== e.bearing_wrt_y) begin
          $error("bearing_wrt_y expected %h actual %h", e.bearing_wrt_y, brg_y); failed = 1;
        end
        if (rte_x !== e.rate_wrt_x) begin
          $error("rate_wrt_x expected %h actual %h", e.rate_wrt_x, rte_x); failed = 1;
        end
        if (rte_y !== e.rate_wrt_y) begin
          $error("rate_wrt_y expected %h actual %h", e.rate_wrt_y, rte_y); failed = 1;
        end
        if (well_def !== e.well_defined) begin
          $error("well_defined expected %b actual %b", e.well_defined, well_def); failed = 1;
        end
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] thr_seq [4];
    int unsigned pct_seq [4];
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    pos_x = '0; pos_y = '0; vel_x = '0; vel_y = '0;
    min_range_model = MIN_RESET;
    sender_idle_pct = 27;
    cycle_count = 0;
    failed = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero and threshold edges, full-scale corners, saturating entries.
    queue_state(32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_state(32'd677, 32'd0, 32'd65536, 32'd0);
    queue_state(32'd678, 32'd0, 32'd65536, 32'd65536);
    queue_state(32'd0, 32'd678, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_state(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_state(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_state(32'hFFFF_FD2A, 32'd0, 32'd0, 32'h8000_0000);
    queue_state(32'd65536, 32'd65536, 32'd65536, 32'hFFFF_0000);
    queue_state(32'hFFFF_0000, 32'd131072, 32'hFFFE_0000, 32'd65536);
    queue_state(32'd1000, 32'hFFFF_FC18, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_state(32'h0003_0000, 32'h0004_0000, 32'd0, 32'd0);
    queue_state(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_state(32'h7FFF_FFFF, 32'd0, 32'd0, 32'h7FFF_FFFF);
    queue_state(32'd0, 32'h8000_0000, 32'h8000_0000, 32'd0);
    wait_drained();

    thr_seq = '{16'd0, 16'hFFFF, 16'd7, 16'd0};
    pct_seq = '{27, 87, 0, 0};
    thr_seq[2] = CFG_W'($urandom);
    for (int ph = 0; ph < 4; ph++) begin
      write_min_range(thr_seq[ph]);
      sender_idle_pct = pct_seq[ph];
      for (int k = 0; k < 260; k++) begin
        queue_state(random_q16(), random_q16(), random_q16(), random_q16());
      end
      wait_drained();
    end

    if (!failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
